### design/spiral_matrix_reorder_macros.svh
// Assertion macros used by the checker of the spiral reorder block.
`ifndef SPIRAL_MATRIX_REORDER_MACROS_SVH
`define SPIRAL_MATRIX_REORDER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SMR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SMR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/smr_pkg.sv
// Package of the spiral reorder block: widths, state codes and control structs.
`timescale 1ns / 1ps
`default_nettype none
package smr_pkg;

	localparam int SIDE_W       = 4;
	localparam int VALUE_W      = 32;
	localparam int MAX_SIDE_DEF = 8;

	typedef enum logic {
		ST_LOAD = 1'b0,
		ST_WALK = 1'b1
	} state_t;

	typedef enum logic [1:0] {
		DIR_LEFT  = 2'd0,
		DIR_UP    = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	typedef struct packed {
		logic cfg_write;
		logic load_en;
		logic walk_start;
		logic walk_step;
	} cmd_t;

	typedef struct packed {
		logic load_last;
		logic walk_last;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

### design/smr_ctrl.sv
// Controller of the spiral reorder block: load and walk sequencing.
`timescale 1ns / 1ps
`default_nettype none
module smr_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  smr_pkg::status_t status,
	output smr_pkg::cmd_t    cmd
);

	smr_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smr_pkg::ST_LOAD;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			smr_pkg::ST_LOAD: begin
				if (in_valid && status.load_last) begin
					state_next = smr_pkg::ST_WALK;
				end
			end
			smr_pkg::ST_WALK: begin
				if (status.out_free && status.walk_last) begin
					state_next = smr_pkg::ST_LOAD;
				end
			end
			default: state_next = smr_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		cfg_ready      = 1'b1;
		cmd            = '0;
		cmd.cfg_write  = cfg_valid;
		unique case (state_q)
			smr_pkg::ST_LOAD: begin
				in_ready       = 1'b1;
				cmd.load_en    = in_valid;
				cmd.walk_start = in_valid && status.load_last;
			end
			smr_pkg::ST_WALK: begin
				cmd.walk_step = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

### design/smr_datapath.sv
// Datapath of the spiral reorder block: element store, counters, walk and output register.
`timescale 1ns / 1ps
`default_nettype none
module smr_datapath #(
	parameter int MAX_SIDE = smr_pkg::MAX_SIDE_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  smr_pkg::cmd_t                      cmd,
	output smr_pkg::status_t                   status,
	input  wire [smr_pkg::SIDE_W-1:0]          side_length,
	input  wire signed [smr_pkg::VALUE_W-1:0]  element_value,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic signed [smr_pkg::VALUE_W-1:0] out_value,
	output logic                               last_of_walk
);

	localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int COORD_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

	logic signed [smr_pkg::VALUE_W-1:0] store_q [DEPTH];

	logic [smr_pkg::SIDE_W-1:0] side_q;
	logic [CNT_W-1:0]           total_q;
	logic [CNT_W-1:0]           load_cnt_q;
	logic [CNT_W-1:0]           emit_cnt_q;
	logic [COORD_W-1:0]         row_q, col_q, lo_row_q, hi_row_q, lo_col_q, hi_col_q;
	logic [ADDR_W-1:0]          idx_q;
	smr_pkg::dir_t              dir_q;
	logic                       out_valid_q;
	logic signed [smr_pkg::VALUE_W-1:0] out_value_q;
	logic                       out_last_q;

	logic [smr_pkg::SIDE_W-1:0] side_sat;
	logic [ADDR_W-1:0]          side_a;
	logic [COORD_W-1:0]         side_m1;

	// Saturate the written side into 1..MAX_SIDE.
	always_comb begin
		priority if (side_length == '0) begin
			side_sat = smr_pkg::SIDE_W'(1);
		end else if (side_length > smr_pkg::SIDE_W'(MAX_SIDE)) begin
			side_sat = smr_pkg::SIDE_W'(MAX_SIDE);
		end else begin
			side_sat = side_length;
		end
	end

	assign side_a  = ADDR_W'(side_q);
	assign side_m1 = COORD_W'(side_q - smr_pkg::SIDE_W'(1));

	assign status.load_last = (load_cnt_q == total_q - CNT_W'(1));
	assign status.walk_last = (emit_cnt_q == total_q - CNT_W'(1));
	assign status.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q  <= smr_pkg::SIDE_W'(1);
			total_q <= CNT_W'(1);
		end else if (cmd.cfg_write) begin
			side_q  <= side_sat;
			total_q <= CNT_W'(side_sat) * CNT_W'(side_sat);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
		end else if (cmd.cfg_write || cmd.walk_start) begin
			load_cnt_q <= '0;
		end else if (cmd.load_en) begin
			load_cnt_q <= load_cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en) begin
			store_q[load_cnt_q[ADDR_W-1:0]] <= element_value;
		end
	end

	// Walk position: index tracks row * side + col by steps of one or one side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_cnt_q <= '0;
			dir_q      <= smr_pkg::DIR_LEFT;
		end else if (cmd.walk_start) begin
			emit_cnt_q <= '0;
			dir_q      <= smr_pkg::DIR_LEFT;
		end else if (cmd.walk_step) begin
			emit_cnt_q <= emit_cnt_q + CNT_W'(1);
			unique case (dir_q)
				smr_pkg::DIR_LEFT:  if (col_q <= lo_col_q) dir_q <= smr_pkg::DIR_UP;
				smr_pkg::DIR_UP:    if (row_q <= lo_row_q) dir_q <= smr_pkg::DIR_RIGHT;
				smr_pkg::DIR_RIGHT: if (col_q >= hi_col_q) dir_q <= smr_pkg::DIR_DOWN;
				smr_pkg::DIR_DOWN:  if (row_q >= hi_row_q) dir_q <= smr_pkg::DIR_LEFT;
				default:            dir_q <= smr_pkg::DIR_LEFT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			row_q    <= side_m1;
			col_q    <= side_m1;
			lo_row_q <= '0;
			lo_col_q <= '0;
			hi_row_q <= side_m1;
			hi_col_q <= side_m1;
			idx_q    <= ADDR_W'(total_q - CNT_W'(1));
		end else if (cmd.walk_step) begin
			unique case (dir_q)
				smr_pkg::DIR_LEFT: begin
					if (col_q > lo_col_q) begin
						col_q <= col_q - COORD_W'(1);
						idx_q <= idx_q - ADDR_W'(1);
					end else begin
						row_q    <= row_q - COORD_W'(1);
						hi_row_q <= hi_row_q - COORD_W'(1);
						idx_q    <= idx_q - side_a;
					end
				end
				smr_pkg::DIR_UP: begin
					if (row_q > lo_row_q) begin
						row_q <= row_q - COORD_W'(1);
						idx_q <= idx_q - side_a;
					end else begin
						col_q    <= col_q + COORD_W'(1);
						lo_col_q <= lo_col_q + COORD_W'(1);
						idx_q    <= idx_q + ADDR_W'(1);
					end
				end
				smr_pkg::DIR_RIGHT: begin
					if (col_q < hi_col_q) begin
						col_q <= col_q + COORD_W'(1);
						idx_q <= idx_q + ADDR_W'(1);
					end else begin
						row_q    <= row_q + COORD_W'(1);
						lo_row_q <= lo_row_q + COORD_W'(1);
						idx_q    <= idx_q + side_a;
					end
				end
				default: begin
					if (row_q < hi_row_q) begin
						row_q <= row_q + COORD_W'(1);
						idx_q <= idx_q + side_a;
					end else begin
						col_q    <= col_q - COORD_W'(1);
						hi_col_q <= hi_col_q - COORD_W'(1);
						idx_q    <= idx_q - ADDR_W'(1);
					end
				end
			endcase
		end
	end

	// Output register doubles as the store's read data register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.walk_step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_step) begin
			out_value_q <= store_q[idx_q];
			out_last_q  <= status.walk_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign last_of_walk = out_last_q;

endmodule
`default_nettype wire

### design/spiral_matrix_reorder.sv
// Top level of the spiral reorder block: controller plus datapath.
//
// Usage: a square matrix streams in on the input channel (in_valid/in_ready,
// element_value), one element per transfer in row-major order. The side is
// set through the configuration channel (cfg_valid/cfg_ready, side_length);
// 0 reads as 1 and values above MAX_SIDE saturate. A configuration transfer
// drops any partly loaded matrix. Write it only while the block is idle.
// After the last element of the matrix, the controller enters its walk
// state, then the output register loads the first result. The walk shows
// one element per cycle on out_value while the receiver is ready, from the
// single read port of the element store, starting bottom-right and
// spiraling left, up, right, down. last_of_walk marks the final element.
// in_ready is low while the walk runs.
// A stalled receiver holds the output register and freezes the walk.
// Reset returns the side to 1 and clears the load count; the store is not
// cleared, since every entry is written before the walk reads it.
`timescale 1ns / 1ps
`default_nettype none
module spiral_matrix_reorder #(
	parameter int MAX_SIDE = smr_pkg::MAX_SIDE_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [smr_pkg::SIDE_W-1:0]          side_length,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire signed [smr_pkg::VALUE_W-1:0]  element_value,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic signed [smr_pkg::VALUE_W-1:0] out_value,
	output logic                               last_of_walk
);

	smr_pkg::cmd_t    cmd;
	smr_pkg::status_t status;

	// Sequence loading and walking; no payload passes through here.
	smr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Hold the store, the side register, the walk position and the output register.
	smr_datapath #(
		.MAX_SIDE (MAX_SIDE)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.side_length   (side_length),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_value     (out_value),
		.last_of_walk  (last_of_walk)
	);

endmodule
`default_nettype wire

### design/smr_checker.sv
// Port-level checker of the spiral reorder block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "spiral_matrix_reorder_macros.svh"
module smr_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               in_ready,
	input wire                               out_valid,
	input wire                               out_ready,
	input wire signed [smr_pkg::VALUE_W-1:0] out_value,
	input wire                               last_of_walk
);

	`SMR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(last_of_walk), "stalled result changed")
	`SMR_ASSERT_NEXT(a_walk_cont, out_valid && out_ready && !last_of_walk, out_valid, "walk paused after a transfer")
	`SMR_ASSERT_NOW(a_no_load_walk, out_valid && !last_of_walk, !in_ready, "input taken during walk")

endmodule

bind spiral_matrix_reorder smr_checker u_smr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_value    (out_value),
	.last_of_walk (last_of_walk)
);
`default_nettype wire

### tb/tb_spiral_matrix_reorder.sv
// Self-checking testbench of the spiral matrix reorder block.
`timescale 1ns / 1ps
module tb_spiral_matrix_reorder;

	localparam int MAX_SIDE      = 8;
	localparam int STORE_DEPTH   = MAX_SIDE * MAX_SIDE;
	localparam int IDLE_PCT      = 30;      // chance per cycle that a side idles
	localparam int SETTLE_CYCLES = 4;       // walk latency plus margin before a register write
	localparam int RANDOM_ITEMS  = 90;
	localparam int CYCLE_LIMIT   = 200000;

	// One element of the spiral walk as the block should present it.
	typedef struct {
		logic signed [smr_pkg::VALUE_W-1:0] value;
		logic                               last;
	} spiral_result_t;

	// Every input starts at a known value; reset is held from time zero.
	logic                               clk           = 1'b0;
	logic                               arst_n        = 1'b0;
	logic                               cfg_valid     = 1'b0;
	logic [smr_pkg::SIDE_W-1:0]         side_length   = '0;
	logic                               in_valid      = 1'b0;
	logic signed [smr_pkg::VALUE_W-1:0] element_value = '0;
	logic                               out_ready     = 1'b0;
	wire                                cfg_ready;
	wire                                in_ready;
	wire                                out_valid;
	wire signed [smr_pkg::VALUE_W-1:0]  out_value;
	wire                                last_of_walk;

	// Predictor state: the side register, the element store and the fill count.
	logic [smr_pkg::SIDE_W-1:0]         side_reg = 4'd1;
	logic signed [smr_pkg::VALUE_W-1:0] matrix_mem [0:STORE_DEPTH-1];
	int unsigned                        fill_count = 0;

	spiral_result_t            pending_results [$];
	int                        fail_count     = 0;
	int                        elements_sent  = 0;
	int unsigned               cycle_count    = 0;
	bit                        steady         = 1'b0;  // suppress idling on both sides

	spiral_matrix_reorder #(.MAX_SIDE(MAX_SIDE)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.side_length  (side_length),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element_value(element_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.last_of_walk (last_of_walk)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: end the run if the handshakes stop moving.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: stall at random unless a steady stretch is running.
	always @(posedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
	end

	// Result checker. Signals are sampled at the edge before any update of this
	// step lands, so valid and ready here are the values the block saw.
	always @(posedge clk) begin : check_results
		spiral_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: out_value %0d last_of_walk %0b",
					out_value, last_of_walk);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_value !== want.value) begin
					$error("out_value: expected %0d, got %0d", want.value, out_value);
					fail_count++;
				end
				if (last_of_walk !== want.last) begin
					$error("last_of_walk: expected %0b, got %0b", want.last, last_of_walk);
					fail_count++;
				end
			end
		end
	end

	// Side in effect: zero reads as one, anything above the maximum saturates.
	function automatic int unsigned side_in_use();
		if (side_reg == 0)
			return 1;
		if (side_reg > MAX_SIDE)
			return MAX_SIDE;
		return 32'(side_reg);
	endfunction

	// Walk the stored matrix from the bottom-right corner: left, up, right,
	// down, pulling the matching boundary in after each full edge.
	task automatic predict_spiral(input int unsigned n);
		int             row;
		int             col;
		int             col_lo;
		int             col_hi;
		int             row_lo;
		int             row_hi;
		int unsigned    total;
		smr_pkg::dir_t  heading;
		spiral_result_t res;
		row     = n - 1;
		col     = n - 1;
		col_lo  = 0;
		col_hi  = n - 1;
		row_lo  = 0;
		row_hi  = n - 1;
		total   = n * n;
		heading = smr_pkg::DIR_LEFT;
		for (int unsigned k = 0; k < total; k++) begin
			res.value = matrix_mem[(row * n + col) % STORE_DEPTH];
			res.last  = (k + 1 == total);
			pending_results.push_back(res);
			case (heading)
				smr_pkg::DIR_LEFT: begin
					if (col > col_lo) begin
						col--;
					end else begin
						row--;
						row_hi--;
						heading = smr_pkg::DIR_UP;
					end
				end
				smr_pkg::DIR_UP: begin
					if (row > row_lo) begin
						row--;
					end else begin
						col++;
						col_lo++;
						heading = smr_pkg::DIR_RIGHT;
					end
				end
				smr_pkg::DIR_RIGHT: begin
					if (col < col_hi) begin
						col++;
					end else begin
						row++;
						row_lo++;
						heading = smr_pkg::DIR_DOWN;
					end
				end
				default: begin
					if (row < row_hi) begin
						row++;
					end else begin
						col--;
						col_hi--;
						heading = smr_pkg::DIR_LEFT;
					end
				end
			endcase
		end
	endtask

	// Store one accepted element; the element that completes the matrix
	// releases the whole walk.
	task automatic absorb_element(input logic signed [smr_pkg::VALUE_W-1:0] v);
		int unsigned total;
		total = side_in_use() * side_in_use();
		if (fill_count >= total)
			fill_count = 0;
		matrix_mem[fill_count % STORE_DEPTH] = v;
		fill_count = (fill_count + 1) & 7'h7f;
		if (fill_count >= total) begin
			fill_count = 0;
			predict_spiral(side_in_use());
		end
	endtask

	// Send one element. Entered at a clock edge; returns at the edge of its
	// transfer with valid still high, so a following element keeps valid up
	// without a drop in between.
	task automatic send_element(input logic signed [smr_pkg::VALUE_W-1:0] v);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		in_valid      <= 1'b1;
		element_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		elements_sent++;
		absorb_element(v);
	endtask

	// Drop valid, wait for every expected result, then let the walk settle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the side register once the block is idle; this also clears the fill.
	task automatic write_side(input logic [smr_pkg::SIDE_W-1:0] s);
		drain_results();
		cfg_valid   <= 1'b1;
		side_length <= s;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		side_reg   = s;
		fill_count = 0;
	endtask

	// Mostly random words, with the signed extremes mixed in.
	function automatic logic signed [smr_pkg::VALUE_W-1:0] pick_element();
		case ($urandom_range(9))
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3:       return -1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_matrix(input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_element(pick_element());
	endtask

	// One-element matrices carry the field extremes straight through.
	task automatic test_single_element();
		write_side(4'd1);
		send_element(32'sh7fff_ffff);
		send_element(32'sh8000_0000);
		send_element('0);
		send_element(-1);
	endtask

	// Smallest real spiral: distinct values make the order visible.
	task automatic test_side_two();
		write_side(4'd2);
		for (int i = 1; i <= 4; i++)
			send_element(i);
	endtask

	// A side of zero behaves as a side of one.
	task automatic test_zero_side();
		write_side(4'd0);
		send_element(pick_element());
	endtask

	// A register write in the middle of a matrix drops what was loaded.
	task automatic test_dropped_partial();
		write_side(4'd3);
		send_matrix(5);
		write_side(4'd2);
		for (int i = 11; i <= 14; i++)
			send_element(i);
	endtask

	// All-ones side saturates to the full matrix; run it with no idling at all.
	task automatic test_saturated_side();
		write_side(4'd15);
		steady = 1'b1;
		send_matrix(STORE_DEPTH);
		drain_results();
		steady = 1'b0;
	endtask

	// Hold the sender until the whole walk is out, then load the next matrix.
	task automatic test_drain_pause();
		write_side(4'd3);
		send_matrix(9);
		drain_results();
		send_matrix(9);
	endtask

	// Random phases: mostly small sides, rarely a large or out-of-range one.
	// A few matrices are cut short so the next register write drops them.
	task automatic test_random_matrices();
		int                         goal;
		int unsigned                total;
		logic [smr_pkg::SIDE_W-1:0] s;
		goal = elements_sent + RANDOM_ITEMS;
		while (elements_sent < goal) begin
			s = smr_pkg::SIDE_W'($urandom_range(0, 7));
			if ($urandom_range(7) == 0)
				s = smr_pkg::SIDE_W'($urandom_range(8, 15));
			write_side(s);
			total = side_in_use() * side_in_use();
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(3) == 0)
					drain_results();
				send_matrix(total);
			end
			if (total > 1 && $urandom_range(7) == 0)
				send_matrix($urandom_range(1, total - 1));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_element();
		test_side_two();
		test_zero_side();
		test_dropped_partial();
		test_saturated_side();
		test_drain_pause();
		test_random_matrices();

		drain_results();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
